[src/reentrant_record_lock_table_macros.svh]
// Assertion macros for the record lock table.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef REENTRANT_RECORD_LOCK_TABLE_MACROS_SVH
`define REENTRANT_RECORD_LOCK_TABLE_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define RRLT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// When the trigger holds, the consequence holds in the next cycle.
`define RRLT_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

[src/rrlt_pkg.sv]
package rrlt_pkg;

  localparam int DefTableEntries = 16;
  localparam int DefOwnerBits    = 8;
  localparam int DefCountBits    = 16;
  localparam int DefRecordBits   = 32;

  localparam int OpcodeW = 2;
  localparam int RecordW = 32;
  localparam int OwnerW  = 8;
  localparam int HoldW   = 16;

  typedef enum logic [OpcodeW-1:0] {
    OP_QUERY      = 2'd0,
    OP_LOCK       = 2'd1,
    OP_UNLOCK     = 2'd2,
    OP_UNLOCK_ALL = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_LOCKED = 3'd1,
    ST_OTHER      = 3'd2,
    ST_FULL       = 3'd3,
    ST_SATURATED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic compare;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

[src/rrlt_if.sv]
interface rrlt_req_if;
  logic                          valid;
  logic                          ready;
  rrlt_pkg::opcode_e             opcode;
  logic [rrlt_pkg::RecordW-1:0]  record_number;
  logic [rrlt_pkg::OwnerW-1:0]   owner_id;

  modport source (output valid, output opcode, output record_number, output owner_id,
                  input ready);
  modport sink (input valid, input opcode, input record_number, input owner_id,
                output ready);
endinterface

interface rrlt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        success;
  rrlt_pkg::status_e           status;
  logic                        is_locked;
  logic [rrlt_pkg::HoldW-1:0]  hold_count;

  modport source (output valid, output success, output status, output is_locked,
                  output hold_count, input ready);
  modport sink (input valid, input success, input status, input is_locked,
                input hold_count, output ready);
endinterface

[src/rrlt_ctrl.sv]
module rrlt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rrlt_pkg::dp_status_t stat_i,
  output rrlt_pkg::ctrl_cmd_t  cmd_o
);
  import rrlt_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_MATCH: begin
        cmd_o.compare = 1'b1;
      end
      S_UPDATE: begin
        cmd_o.commit = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

[src/rrlt_datapath.sv]
module rrlt_datapath #(
  parameter int TABLE_ENTRIES = rrlt_pkg::DefTableEntries,
  parameter int OWNER_BITS    = rrlt_pkg::DefOwnerBits,
  parameter int COUNT_BITS    = rrlt_pkg::DefCountBits,
  parameter int RECORD_BITS   = rrlt_pkg::DefRecordBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rrlt_pkg::ctrl_cmd_t          cmd_i,
  output rrlt_pkg::dp_status_t         stat_o,
  input  rrlt_pkg::opcode_e            opcode_i,
  input  logic [rrlt_pkg::RecordW-1:0] record_number_i,
  input  logic [rrlt_pkg::OwnerW-1:0]  owner_id_i,
  rrlt_rsp_if.source                   rsp_o
);
  import rrlt_pkg::*;

  localparam int RecW = (RECORD_BITS < RecordW) ? RECORD_BITS : RecordW;
  localparam int OwnW = (OWNER_BITS < OwnerW) ? OWNER_BITS : OwnerW;
  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam logic [COUNT_BITS-1:0] CntMax = '1;
  localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);

  opcode_e                    op_q;
  logic [RecW-1:0]            rec_q;
  logic [OwnW-1:0]            own_q;

  logic [RecW-1:0]            ent_rec_q [TABLE_ENTRIES];
  logic [OwnW-1:0]            ent_own_q [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0]      ent_cnt_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]   ent_valid_q;

  logic [TABLE_ENTRIES-1:0]   match_q, match_d;
  logic [TABLE_ENTRIES-1:0]   free_q;

  logic                       hit;
  logic                       full;
  logic [IdxW-1:0]            hit_idx;
  logic [IdxW-1:0]            free_idx;
  logic [OwnW-1:0]            hit_own;
  logic [COUNT_BITS-1:0]      hit_cnt;

  logic                       res_ok;
  status_e                    res_status;
  logic                       res_locked;
  logic [COUNT_BITS-1:0]      res_cnt;
  logic [31:0]                res_cnt_ext;
  logic                       wr_new;
  logic                       wr_cnt;
  logic                       wr_free;

  logic                       out_valid_q;
  logic                       success_q;
  status_e                    status_q;
  logic                       is_locked_q;
  logic [HoldW-1:0]           hold_count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      rec_q <= RecW'(record_number_i);
      own_q <= OwnW'(owner_id_i);
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_d[i] = ent_valid_q[i] && (ent_rec_q[i] == rec_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      match_q <= match_d;
      free_q  <= ~ent_valid_q;
    end
  end

  // Records are unique in the table, so the match vector is one-hot or empty.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (match_q[i]) begin
        hit_idx = hit_idx | IdxW'(i);
      end
    end
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  assign hit     = |match_q;
  assign full    = ~|free_q;
  assign hit_own = ent_own_q[hit_idx];
  assign hit_cnt = ent_cnt_q[hit_idx];

  always_comb begin
    res_ok     = 1'b0;
    res_status = ST_OK;
    res_locked = 1'b0;
    res_cnt    = '0;
    wr_new     = 1'b0;
    wr_cnt     = 1'b0;
    wr_free    = 1'b0;
    case (op_q)
      OP_QUERY: begin
        if (hit) begin
          res_ok     = 1'b1;
          res_locked = 1'b1;
          res_cnt    = hit_cnt;
        end else begin
          res_status = ST_NOT_LOCKED;
        end
      end
      OP_LOCK: begin
        if (!hit) begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            wr_new     = 1'b1;
            res_ok     = 1'b1;
            res_locked = 1'b1;
            res_cnt    = CntOne;
          end
        end else if (hit_own != own_q) begin
          res_status = ST_OTHER;
          res_locked = 1'b1;
          res_cnt    = hit_cnt;
        end else if (hit_cnt == CntMax) begin
          res_status = ST_SATURATED;
          res_locked = 1'b1;
          res_cnt    = hit_cnt;
        end else begin
          wr_cnt     = 1'b1;
          res_ok     = 1'b1;
          res_locked = 1'b1;
          res_cnt    = hit_cnt + CntOne;
        end
      end
      default: begin
        if (!hit) begin
          res_status = ST_NOT_LOCKED;
        end else if (hit_own != own_q) begin
          res_status = ST_OTHER;
          res_locked = 1'b1;
          res_cnt    = hit_cnt;
        end else begin
          res_ok = 1'b1;
          if ((op_q == OP_UNLOCK) && (hit_cnt > CntOne)) begin
            wr_cnt     = 1'b1;
            res_locked = 1'b1;
            res_cnt    = hit_cnt - CntOne;
          end else begin
            wr_free = 1'b1;
          end
        end
      end
    endcase
  end

  assign res_cnt_ext = 32'(res_cnt);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_new) begin
      ent_rec_q[free_idx] <= rec_q;
      ent_own_q[free_idx] <= own_q;
      ent_cnt_q[free_idx] <= CntOne;
    end else if (cmd_i.commit && wr_cnt) begin
      ent_cnt_q[hit_idx] <= res_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
    end else if (cmd_i.commit) begin
      if (wr_new) begin
        ent_valid_q[free_idx] <= 1'b1;
      end else if (wr_free) begin
        ent_valid_q[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      success_q    <= res_ok;
      status_q     <= res_status;
      is_locked_q  <= res_locked;
      hold_count_q <= res_cnt_ext[HoldW-1:0];
    end
  end

  assign stat_o.out_free  = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.success    = success_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.is_locked  = is_locked_q;
  assign rsp_o.hold_count = hold_count_q;

endmodule

[src/reentrant_record_lock_table.sv]
// A word is handled in order: the request is registered at acceptance, the parallel
// record compare is registered after that, and the entry update then loads the
// output register. A new word is accepted only once that update is done, so the
// controller handles one word at a time.
// The update waits while the previous response is still unread, which stalls the input.
// Reset is asynchronous and active low; it empties the table at once.
module reentrant_record_lock_table #(
  parameter int TABLE_ENTRIES = rrlt_pkg::DefTableEntries,
  parameter int OWNER_BITS    = rrlt_pkg::DefOwnerBits,
  parameter int COUNT_BITS    = rrlt_pkg::DefCountBits,
  parameter int RECORD_BITS   = rrlt_pkg::DefRecordBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrlt_req_if.sink   req_i,
  rrlt_rsp_if.source rsp_o
);
  import rrlt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  rrlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rrlt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .OWNER_BITS    (OWNER_BITS),
    .COUNT_BITS    (COUNT_BITS),
    .RECORD_BITS   (RECORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .opcode_i        (req_i.opcode),
    .record_number_i (req_i.record_number),
    .owner_id_i      (req_i.owner_id),
    .rsp_o           (rsp_o)
  );

`include "reentrant_record_lock_table_macros.svh"

  `RRLT_ASSERT_NEXT(a_busy_after_accept, req_i.valid && req_i.ready, !req_i.ready, "accepted while busy")
  `RRLT_ASSERT(a_cmd_exclusive, $onehot0({cmd.load, cmd.compare, cmd.commit}), "overlapping commands")
  `RRLT_ASSERT(a_commit_room, !cmd.commit || !rsp_o.valid || rsp_o.ready, "response overwritten")
  `RRLT_ASSERT_NEXT(a_commit_valid, cmd.commit, rsp_o.valid, "commit without response")

endmodule
